// ===== hw/rtl/bmh_pkg.sv =====
// Shared constants, microcode types and the control store of the heap builder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bmh_pkg;

  localparam int HEAP_DEPTH = 16;
  localparam int VALUE_W    = 32;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  // Child indexes reach 2*HEAP_DEPTH, so two bits more than an entry index.
  localparam int KID_W      = IDX_W + 2;
  localparam int STEP_W     = 4;

  typedef enum logic [3:0] {
    A_LOAD,   // take one input transaction into the store
    A_BINIT,  // first parent index from the loaded count
    A_BNEXT,  // step to the next parent, read its value
    A_PV,     // latch parent value, read left child
    A_RL,     // read left child of the current position
    A_RR,     // latch left child, read right child
    A_CMP,    // pick the largest of parent and children
    A_WPOS,   // write the winning child into the parent slot
    A_WTOP,   // write the sifted value into the child slot
    A_EINIT,  // read the root for emission
    A_EMIT    // present one entry on the output
  } action_t;

  typedef enum logic [2:0] {
    C_NEXT,   // fall through
    C_JUMP,   // always jump
    C_LAST,   // jump on a last input transaction, else stay
    C_PZERO,  // jump when no parent is left, else fall through
    C_TOPEQ,  // jump when the parent already wins, else fall through
    C_EMIT    // stay until the final entry is sent, then jump
  } cond_t;

  typedef struct packed {
    action_t             act;
    cond_t               cond;
    logic [STEP_W-1:0]   target;
  } uword_t;

  typedef struct packed {
    logic in_acc;
    logic last;
    logic p_zero;
    logic top_eq;
    logic emit_go;
    logic fin;
  } status_t;

  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_BINIT = 4'd1;
  localparam logic [STEP_W-1:0] S_BNEXT = 4'd2;
  localparam logic [STEP_W-1:0] S_PV    = 4'd3;
  localparam logic [STEP_W-1:0] S_RL    = 4'd4;
  localparam logic [STEP_W-1:0] S_RR    = 4'd5;
  localparam logic [STEP_W-1:0] S_CMP   = 4'd6;
  localparam logic [STEP_W-1:0] S_WPOS  = 4'd7;
  localparam logic [STEP_W-1:0] S_WTOP  = 4'd8;
  localparam logic [STEP_W-1:0] S_EINIT = 4'd9;
  localparam logic [STEP_W-1:0] S_EMIT  = 4'd10;

  // The control store. Unused step codes fall back to the idle word.
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      S_IDLE:  w = '{act: A_LOAD,  cond: C_LAST,  target: S_BINIT};
      S_BINIT: w = '{act: A_BINIT, cond: C_NEXT,  target: S_BNEXT};
      S_BNEXT: w = '{act: A_BNEXT, cond: C_PZERO, target: S_EINIT};
      S_PV:    w = '{act: A_PV,    cond: C_JUMP,  target: S_RR};
      S_RL:    w = '{act: A_RL,    cond: C_NEXT,  target: S_RR};
      S_RR:    w = '{act: A_RR,    cond: C_NEXT,  target: S_CMP};
      S_CMP:   w = '{act: A_CMP,   cond: C_NEXT,  target: S_WPOS};
      S_WPOS:  w = '{act: A_WPOS,  cond: C_TOPEQ, target: S_BNEXT};
      S_WTOP:  w = '{act: A_WTOP,  cond: C_JUMP,  target: S_RL};
      S_EINIT: w = '{act: A_EINIT, cond: C_NEXT,  target: S_EMIT};
      S_EMIT:  w = '{act: A_EMIT,  cond: C_EMIT,  target: S_IDLE};
      default: w = '{act: A_LOAD,  cond: C_LAST,  target: S_BINIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmh_in_if.sv =====
// Input channel of the heap builder: valid/ready plus value and last.
// Depends on bmh_pkg for the value width.
`default_nettype none

interface bmh_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmh_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmh_out_if.sv =====
// Output channel of the heap builder: valid/ready plus one heap entry and flags.
// Depends on bmh_pkg for the value width.
`default_nettype none

interface bmh_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmh_pkg::VALUE_W-1:0] heap_value;
  logic                        end_of_heap;
  logic                        overflow;

  modport source (output valid, output heap_value, output end_of_heap, output overflow,
                  input ready);
  modport sink   (input valid, input heap_value, input end_of_heap, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/build_max_heap_top.sv =====
// Top level of the max-heap builder: microcode sequencer plus datapath.
// Depends on bmh_pkg, bmh_in_if, bmh_out_if, bmh_seq and bmh_dp.
//
//   Channel  Dir  Payload                               Transaction
//   feed     in   value[31:0], last                     one value loaded
//   heap     out  heap_value[31:0], end_of_heap, overflow  one heap entry
//
// Values are taken while the builder is idle. After a last transaction it builds
// the heap by sifting down each parent in turn, from the last parent to the root,
// then emits the entries in store order, starting at the root. The single-port entry
// store is read or written at most once per micro-step.
// Reset clears the step counter, fill count, drop flag and output valid.
// A stalled output holds the emission step; no input is taken until the
// final entry of a set has been handed to the output register.
`default_nettype none

module build_max_heap_top (
  input  wire logic clk,
  input  wire logic rst,
  bmh_in_if.sink    feed,
  bmh_out_if.source heap
);

  bmh_pkg::action_t act;
  bmh_pkg::status_t status;

  bmh_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .act    (act)
  );

  bmh_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .act    (act),
    .status (status),
    .feed   (feed),
    .heap   (heap)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bmh_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on bmh_pkg for the control word, status struct and control store.
`default_nettype none

module bmh_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bmh_pkg::status_t status,
  output bmh_pkg::action_t      act
);

  localparam int SW = bmh_pkg::STEP_W;

  logic [bmh_pkg::STEP_W-1:0] step;
  logic [bmh_pkg::STEP_W-1:0] step_next;
  bmh_pkg::uword_t            uw;

  assign uw  = bmh_pkg::ucode(step);
  assign act = uw.act;

  always_comb begin
    case (uw.cond)
      bmh_pkg::C_NEXT:  step_next = step + SW'(1);
      bmh_pkg::C_JUMP:  step_next = uw.target;
      bmh_pkg::C_LAST:  step_next = (status.in_acc && status.last) ? uw.target : step;
      bmh_pkg::C_PZERO: step_next = status.p_zero ? uw.target : step + SW'(1);
      bmh_pkg::C_TOPEQ: step_next = status.top_eq ? uw.target : step + SW'(1);
      bmh_pkg::C_EMIT:  step_next = (status.emit_go && status.fin) ? uw.target : step;
      default:          step_next = bmh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bmh_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bmh_dp.sv =====
// Datapath of the heap builder: entry store, index and value registers,
// comparator and output register, all steered by the current micro-action.
// Depends on bmh_pkg, bmh_in_if and bmh_out_if.
`default_nettype none

module bmh_dp (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bmh_pkg::action_t act,
  output bmh_pkg::status_t      status,
  bmh_in_if.sink                feed,
  bmh_out_if.source             heap
);

  localparam int VW = bmh_pkg::VALUE_W;
  localparam int IW = bmh_pkg::IDX_W;
  localparam int CW = bmh_pkg::CNT_W;
  localparam int KW = bmh_pkg::KID_W;

  logic [VW-1:0] mem [bmh_pkg::HEAP_DEPTH];
  logic [VW-1:0] rdata;

  logic [CW-1:0] cnt;
  logic          dropped;
  logic [CW-1:0] p;
  logic [IW-1:0] pos;
  logic [IW-1:0] top;
  logic [VW-1:0] pv;
  logic [VW-1:0] lv;
  logic [VW-1:0] topv;
  logic [IW-1:0] k;

  logic          out_valid;
  logic [VW-1:0] out_value;
  logic          out_end;
  logic          out_ovf;

  logic          in_acc;
  logic          has_room;
  logic          emit_go;
  logic          emit_fire;
  logic          fin;
  logic [CW-1:0] p_dec;
  logic [KW-1:0] left;
  logic [KW-1:0] right;
  logic [IW-1:0] cmp_top;
  logic [VW-1:0] cmp_val;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  assign feed.ready  = (act == bmh_pkg::A_LOAD);
  assign in_acc      = feed.valid && feed.ready;
  assign has_room    = (cnt != CW'(bmh_pkg::HEAP_DEPTH));
  assign emit_go     = !out_valid || heap.ready;
  assign emit_fire   = (act == bmh_pkg::A_EMIT) && emit_go;
  assign fin         = ((CW'(k) + CW'(1)) == cnt);
  assign p_dec       = p - CW'(1);
  assign left        = KW'({pos, 1'b1});
  assign right       = left + KW'(1);

  assign status.in_acc  = in_acc;
  assign status.last    = feed.last;
  assign status.p_zero  = (p == '0);
  assign status.top_eq  = (top == pos);
  assign status.emit_go = emit_go;
  assign status.fin     = fin;

  // Largest of parent, left and right; the right child arrives on the read port.
  // Strict compares keep the parent on a tie and the left child over the right.
  always_comb begin
    cmp_top = pos;
    cmp_val = pv;
    if ((left < KW'(cnt)) && (lv > cmp_val)) begin
      cmp_top = left[IW-1:0];
      cmp_val = lv;
    end
    if ((right < KW'(cnt)) && (rdata > cmp_val)) begin
      cmp_top = right[IW-1:0];
      cmp_val = rdata;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (act)
      bmh_pkg::A_LOAD: begin
        wr_en   = in_acc && has_room;
        wr_addr = cnt[IW-1:0];
        wr_data = feed.value;
      end
      bmh_pkg::A_BNEXT: begin
        rd_en   = 1'b1;
        rd_addr = p_dec[IW-1:0];
      end
      bmh_pkg::A_PV, bmh_pkg::A_RL: begin
        rd_en   = 1'b1;
        rd_addr = left[IW-1:0];
      end
      bmh_pkg::A_RR: begin
        rd_en   = 1'b1;
        rd_addr = right[IW-1:0];
      end
      bmh_pkg::A_WPOS: begin
        wr_en   = (top != pos);
        wr_addr = pos;
        wr_data = topv;
      end
      bmh_pkg::A_WTOP: begin
        wr_en   = 1'b1;
        wr_addr = top;
        wr_data = pv;
      end
      bmh_pkg::A_EINIT: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      bmh_pkg::A_EMIT: begin
        rd_en   = emit_fire;
        rd_addr = k + IW'(1);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Index and value registers.
  always_ff @(posedge clk) begin
    case (act)
      bmh_pkg::A_BINIT: p <= cnt >> 1;
      bmh_pkg::A_BNEXT: begin
        p   <= p_dec;
        pos <= p_dec[IW-1:0];
      end
      bmh_pkg::A_PV:    pv <= rdata;
      bmh_pkg::A_RR:    lv <= rdata;
      bmh_pkg::A_CMP: begin
        top  <= cmp_top;
        topv <= cmp_val;
      end
      bmh_pkg::A_WTOP:  pos <= top;
      bmh_pkg::A_EINIT: k <= '0;
      bmh_pkg::A_EMIT: begin
        if (emit_fire) begin
          k <= k + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Fill count and drop flag; both clear once the final entry goes out.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end else if (in_acc) begin
      if (has_room) begin
        cnt <= cnt + CW'(1);
      end else begin
        dropped <= 1'b1;
      end
    end else if (emit_fire && fin) begin
      cnt     <= '0;
      dropped <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (heap.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_value <= rdata;
      out_end   <= fin;
      out_ovf   <= fin && dropped;
    end
  end

  assign heap.valid       = out_valid;
  assign heap.heap_value  = out_value;
  assign heap.end_of_heap = out_end;
  assign heap.overflow    = out_ovf;

endmodule

`default_nettype wire
